// ----- rtl/wtr_pkg.sv -----
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared widths, register codes and types for the work-length retarget block.
// ----------------------------------------------------------------------------
`default_nettype none

package wtr_pkg;

  localparam int LEN_W  = 32;  // last_length
  localparam int TIME_W = 40;  // block timestamps
  localparam int TS_W   = 28;  // target_timespan, also the divisor
  localparam int MAX_W  = 34;  // max_length_limit and next_length
  localparam int SPAN_W = TS_W + 2;        // clamped span, up to 4x target
  localparam int PROD_W = LEN_W + SPAN_W;  // length * span
  localparam int QUO_W  = MAX_W;           // quotient bits, one per stage
  localparam int REM_W  = TS_W;            // partial remainder

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MAX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TIMESPAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_RETARGET      = 2'd2;

  localparam logic [TS_W-1:0]  TARGET_TIMESPAN_RST  = 28'd1209600;
  localparam logic [MAX_W-1:0] MAX_LENGTH_LIMIT_RST = 34'd4294967295;

  typedef struct packed {
    logic [TS_W-1:0]  target_timespan;
    logic [MAX_W-1:0] max_length_limit;
    logic             no_retarget;
  } wtr_cfg_t;

  // per-stage control riding along with the data
  typedef struct packed {
    logic valid;
    logic bypass;  // skip divide: pass-through mode or zero target span
  } wtr_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/wtr_if.sv -----
// ----------------------------------------------------------------------------
// wtr_in_if / wtr_out_if
// Valid/ready channels carrying retarget requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtr_in_if import wtr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  last_length;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] first_time;

  modport source (output valid, output last_length, output last_time,
                  output first_time, input ready);
  modport sink   (input valid, input last_length, input last_time,
                  input first_time, output ready);
endinterface

interface wtr_out_if import wtr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAX_W-1:0] next_length;

  modport source (output valid, output next_length, input ready);
  modport sink   (input valid, input next_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/wtr_front.sv -----
// ----------------------------------------------------------------------------
// wtr_front
// Span clamp stage followed by the length * span multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_front import wtr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire wtr_cfg_t          cfg,
  input  wire logic              in_valid,
  input  wire logic [LEN_W-1:0]  last_length,
  input  wire logic [TIME_W-1:0] last_time,
  input  wire logic [TIME_W-1:0] first_time,
  output wtr_ctl_t               ctl,
  output logic [PROD_W-1:0]      prod
);

  logic [TIME_W:0]   diff;
  logic [SPAN_W-1:0] lo;
  logic [SPAN_W-1:0] hi;
  logic [SPAN_W-1:0] span_next;

  wtr_ctl_t          ctl_a;
  logic [LEN_W-1:0]  len_a;
  logic [SPAN_W-1:0] span_a;

  // stage A: clamp the elapsed span to [target/4, target*4]
  always_comb begin
    diff = {1'b0, last_time} - {1'b0, first_time};
    lo   = SPAN_W'(cfg.target_timespan[TS_W-1:2]);
    hi   = {cfg.target_timespan, 2'b00};
    if (diff[TIME_W] || (diff[TIME_W-1:0] < TIME_W'(lo))) begin
      span_next = lo;
    end else if (diff[TIME_W-1:0] > TIME_W'(hi)) begin
      span_next = hi;
    end else begin
      span_next = diff[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (adv) begin
      ctl_a.valid  <= in_valid;
      ctl_a.bypass <= cfg.no_retarget || (cfg.target_timespan == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_a  <= last_length;
      span_a <= span_next;
    end
  end

  // stage B: multiply; bypass loads the pass-through value, or zero for a zero target span, as the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl_a.bypass) begin
        prod <= cfg.no_retarget ? PROD_W'(len_a) : '0;
      end else begin
        prod <= PROD_W'(len_a) * PROD_W'(span_a);
      end
    end
  end

`ifndef SYNTHESIS
  a_bypass_fits : assert property (@(posedge clk) disable iff (rst)
    ctl.valid && ctl.bypass |-> prod[PROD_W-1:LEN_W] == '0)
    else $error("bypass product wider than a length");
`endif

endmodule

`default_nettype wire

// ----- rtl/wtr_div.sv -----
// ----------------------------------------------------------------------------
// wtr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wtr_div import wtr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [TS_W-1:0]   divisor,
  input  wire wtr_ctl_t          ctl_in,
  input  wire logic [PROD_W-1:0] word_in,
  output wtr_ctl_t               ctl_out,
  output logic [QUO_W-1:0]       quo
);

  // word layout: {partial remainder, dividend bits not yet used / quotient}
  // quotient < 2^QUO_W since it is at most 4 * last_length
  logic [PROD_W-1:0] word_q [0:QUO_W];
  wtr_ctl_t          ctl_q  [0:QUO_W];

  assign word_q[0] = word_in;
  assign ctl_q[0]  = ctl_in;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [REM_W:0]    trial;
    logic [REM_W+1:0]  sub;
    logic              ge;
    logic [PROD_W-1:0] word_next;

    always_comb begin
      trial = {word_q[i][PROD_W-1:QUO_W], word_q[i][QUO_W-1]};
      sub   = {1'b0, trial} - {2'b00, divisor};
      ge    = !sub[REM_W+1];
      if (ctl_q[i].bypass) begin
        word_next = word_q[i];
      end else begin
        word_next = {(ge ? sub[REM_W-1:0] : trial[REM_W-1:0]),
                     word_q[i][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[i+1] <= '0;
      end else if (adv) begin
        ctl_q[i+1] <= ctl_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_q[i+1] <= word_next;
      end
    end
  end

  assign ctl_out = ctl_q[QUO_W];
  assign quo     = word_q[QUO_W][QUO_W-1:0];

`ifndef SYNTHESIS
  a_bypass_len : assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid && ctl_out.bypass |-> quo[QUO_W-1:LEN_W] == '0)
    else $error("bypassed request altered in divider");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctl_out) && $stable(quo))
    else $error("divider moved while stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/work_target_retarget_top.sv -----
// ----------------------------------------------------------------------------
// work_target_retarget_top
// Clamped work-length retarget: next length from last length and interval
// end times, with a configurable target span, cap and pass-through mode.
//
// Usage:
//   item   : request channel (last_length, last_time, first_time), valid/ready.
//   result : one next_length per request, in order, valid/ready.
//   cfg_*  : register write port, index 0 target_timespan, 1 max_length_limit,
//            2 no_retarget; write only while no request is in flight.
// Pipeline: from acceptance to result valid a request passes the clamp, multiply,
//   34 divider stages (one quotient bit each) and the capped output register.
// Throughput: one request per cycle unless the output stalls; the whole pipeline advances together.
// Stall: when the output register holds a result that is not taken, every
//   stage holds and item.ready drops; nothing is lost or repeated.
// Reset: synchronous; clears all valid bits and loads the register defaults
//   (target 1209600, limit 4294967295, retargeting on).
// ----------------------------------------------------------------------------
`default_nettype none

module work_target_retarget_top import wtr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  wtr_in_if.sink                     item,
  wtr_out_if.source                  result
);

  wtr_cfg_t          cfg;
  logic              adv;
  logic              out_valid;
  logic [MAX_W-1:0]  next_length;
  logic [MAX_W-1:0]  capped;

  wtr_ctl_t          front_ctl;
  logic [PROD_W-1:0] front_prod;
  wtr_ctl_t          div_ctl;
  logic [QUO_W-1:0]  div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_timespan  <= TARGET_TIMESPAN_RST;
      cfg.max_length_limit <= MAX_LENGTH_LIMIT_RST;
      cfg.no_retarget      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_TIMESPAN:  cfg.target_timespan  <= cfg_wdata[TS_W-1:0];
        CFG_MAX_LENGTH_LIMIT: cfg.max_length_limit <= cfg_wdata[MAX_W-1:0];
        CFG_NO_RETARGET:      cfg.no_retarget      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid || result.ready;
  assign item.ready = adv;

  wtr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .in_valid    (item.valid),
    .last_length (item.last_length),
    .last_time   (item.last_time),
    .first_time  (item.first_time),
    .ctl         (front_ctl),
    .prod        (front_prod)
  );

  wtr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .divisor (cfg.target_timespan),
    .ctl_in  (front_ctl),
    .word_in (front_prod),
    .ctl_out (div_ctl),
    .quo     (div_quo)
  );

  // pass-through is not capped
  assign capped = (!cfg.no_retarget && (div_quo > cfg.max_length_limit)) ?
                  cfg.max_length_limit : div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      next_length <= capped;
    end
  end

  assign result.valid       = out_valid;
  assign result.next_length = next_length;

`ifndef SYNTHESIS
  a_out_follows : assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(adv) |-> out_valid == $past(div_ctl.valid))
    else $error("output valid does not follow last divider stage");
  a_front_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(front_ctl) && $stable(front_prod))
    else $error("front stages moved while stalled");
  a_no_accept_stalled : assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid)
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

// ----- dv/work_target_retarget_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_target_retarget_checker
// Watches the request and result channels and the register write port of the
// retarget block. Each accepted request is run through an independent model of
// the clamp, scale, divide and cap, and the expected length is queued. Each
// accepted result is compared against the oldest queued length.
// ----------------------------------------------------------------------------

module work_target_retarget_checker import wtr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wtr_in_if                     item,
  wtr_out_if                    result,
  output int                    fail_count,
  output int                    pending
);

  localparam int MAX_SHOWN = 100;

  wtr_cfg_t         cfg;
  logic [MAX_W-1:0] next_length_q[$];
  logic [MAX_W-1:0] want_len;

  // next length under the current register settings
  function automatic logic [MAX_W-1:0] retarget_length(input logic [LEN_W-1:0]  len,
                                                       input logic [TIME_W-1:0] t_last,
                                                       input logic [TIME_W-1:0] t_first);
    logic [TIME_W-1:0] span_min;
    logic [TIME_W-1:0] span_max;
    logic [TIME_W-1:0] span;
    logic [63:0]       scaled;
    logic [63:0]       quo;
    if (cfg.no_retarget) begin
      return MAX_W'(len);
    end
    span_min = TIME_W'(cfg.target_timespan >> 2);
    span_max = TIME_W'(cfg.target_timespan) << 2;
    // time running backwards counts as the shortest span
    if (t_last < t_first) begin
      span = span_min;
    end else begin
      span = t_last - t_first;
      if (span < span_min) span = span_min;
    end
    if (span > span_max) span = span_max;
    scaled = 64'(len) * 64'(span);
    if (cfg.target_timespan == '0) begin
      quo = '0;
    end else begin
      quo = scaled / 64'(cfg.target_timespan);
    end
    if (quo > 64'(cfg.max_length_limit)) quo = 64'(cfg.max_length_limit);
    return quo[MAX_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.target_timespan  <= TARGET_TIMESPAN_RST;
      cfg.max_length_limit <= MAX_LENGTH_LIMIT_RST;
      cfg.no_retarget      <= 1'b0;
      next_length_q.delete();
      pending <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (next_length_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding",
                                    result.next_length));
        end else begin
          want_len = next_length_q.pop_front();
          if (result.next_length !== want_len) begin
            report_mismatch($sformatf("next_length got %h want %h",
                                      result.next_length, want_len));
          end
        end
      end
      if (item.valid && item.ready) begin
        next_length_q.push_back(retarget_length(item.last_length, item.last_time,
                                                item.first_time));
      end
      pending <= next_length_q.size();
      // the user must write only while idle (not enforced here), so the order against the checks is moot
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_TIMESPAN:  cfg.target_timespan  <= cfg_wdata[TS_W-1:0];
          CFG_MAX_LENGTH_LIMIT: cfg.max_length_limit <= cfg_wdata[MAX_W-1:0];
          CFG_NO_RETARGET:      cfg.no_retarget      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/work_target_retarget_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_target_retarget_top_test
// Drives the retarget block with directed corner requests and then phases of
// random requests under changing register settings, with random gaps on the
// request side and random stalls on the result side. Checking is done by the
// checker instance; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module work_target_retarget_top_test;
  import wtr_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int SETTLE_CYCLES   = 40;  // longer than the pipeline latency
  localparam int IDLE_PCT        = 38;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [MAX_W-1:0]  LIM_MAX  = '1;
  localparam logic [TS_W-1:0]   TS_MAX   = '1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    in_idle_pct;
  int                    out_idle_pct;
  logic [TS_W-1:0]       cur_ts;

  wtr_in_if  item ();
  wtr_out_if result ();

  work_target_retarget_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .result    (result)
  );

  work_target_retarget_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // low first, so the first rising edge comes after time zero
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_req(input logic [LEN_W-1:0]  len,
                          input logic [TIME_W-1:0] t_last,
                          input logic [TIME_W-1:0] t_first);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < in_idle_pct) @(posedge clk);
    end
    item.valid       <= 1'b1;
    item.last_length <= len;
    item.last_time   <= t_last;
    item.first_time  <= t_first;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  // hold off until every request has its result, then let the pipe settle
  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [TS_W-1:0]  ts,
                           input logic [MAX_W-1:0] lim,
                           input logic             bypass);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_TIMESPAN;
    cfg_wdata <= CFG_DATA_W'(ts);
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH_LIMIT;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_index <= CFG_NO_RETARGET;
    cfg_wdata <= CFG_DATA_W'(bypass);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ts = ts;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 3))
      0:       return LEN_W'($urandom_range(0, 1000));
      1:       return LEN_MAX;
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // elapsed span aimed around the clamp window of target span ts
  function automatic logic [TIME_W-1:0] pick_span(input logic [TS_W-1:0] ts);
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    lo = TIME_W'(ts >> 2);
    hi = TIME_W'(ts) << 2;
    case ($urandom_range(0, 5))
      0, 1:    return lo + (TIME_W'($urandom) % (hi - lo + 1));
      2:       return TIME_W'($urandom) % (lo + 1);
      3:       return hi + TIME_W'($urandom_range(0, 1000));
      4: begin
        case ($urandom_range(0, 4))
          0:       return lo;
          1:       return hi;
          2:       return lo - 1;
          3:       return hi + 1;
          default: return TIME_W'(ts);
        endcase
      end
      default: return rand_time();
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_ts();
    case ($urandom_range(0, 3))
      0:       return TS_W'($urandom_range(4, 64));
      1:       return TS_W'($urandom_range(65, 2000000));
      2:       return TS_MAX;
      default: return TS_W'($urandom_range(4, TS_MAX));
    endcase
  endfunction

  function automatic logic [MAX_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return LIM_MAX;
      1:       return MAX_W'($urandom);
      2:       return MAX_W'($urandom_range(0, 100000));
      default: return {2'($urandom), 32'($urandom)};
    endcase
  endfunction

  initial begin
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] t_first;
    logic [TIME_W-1:0] t_last;
    logic [TS_W-1:0]   ts;
    logic [MAX_W-1:0]  lim;
    logic              bypass;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_TARGET_TIMESPAN;
    cfg_wdata        <= '0;
    item.valid       <= 1'b0;
    item.last_length <= '0;
    item.last_time   <= '0;
    item.first_time  <= '0;
    in_idle_pct      = IDLE_PCT;
    out_idle_pct     = IDLE_PCT;
    cur_ts           = TARGET_TIMESPAN_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: target 1209600, clamp window 302400 .. 4838400
    send_req(LEN_MAX, 40'd1210600, 40'd1000);
    send_req(LEN_MAX, TIME_MAX, '0);                  // clamped high, then capped
    send_req(32'd12345, '0, TIME_MAX);                // time running backwards
    send_req(LEN_MAX, TIME_MAX, TIME_MAX);            // zero elapsed
    send_req('0, 40'd5000000, '0);
    send_req(32'h89ABCDEF, 40'd302399, '0);
    send_req(32'h89ABCDEF, 40'd302400, '0);
    send_req(32'h89ABCDEF, 40'd4838400, '0);
    send_req(32'h89ABCDEF, 40'd4838401, '0);
    send_req(LEN_MAX, TIME_MAX, TIME_MAX - 1);

    // zero target span: product and result are zero
    write_cfg('0, LIM_MAX, 1'b0);
    send_req(LEN_MAX, 40'd100, '0);
    send_req(LEN_MAX, '0, 40'd100);
    // tiny spans, full 34-bit result
    write_cfg(28'd1, LIM_MAX, 1'b0);
    send_req(LEN_MAX, TIME_MAX, '0);
    send_req(32'h12345678, 40'd3, '0);
    send_req(32'h55555555, '0, '0);
    write_cfg(28'd3, '0, 1'b0);
    send_req(LEN_MAX, 40'd10, '0);
    // pass-through ignores the cap
    write_cfg(28'd4, 34'd5, 1'b1);
    send_req(LEN_MAX, '0, '0);
    send_req(32'hA5A5A5A5, TIME_MAX, '0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin ts = 28'd4;  lim = LIM_MAX; bypass = 1'b0; end
        1: begin ts = TS_MAX; lim = LIM_MAX; bypass = 1'b0; end
        2: begin ts = pick_ts(); lim = pick_limit(); bypass = 1'b1; end
        default: begin
          ts     = pick_ts();
          lim    = pick_limit();
          bypass = ($urandom_range(0, 7) == 0);
        end
      endcase
      write_cfg(ts, lim, bypass);
      // one long stretch with no gaps or stalls at all
      in_idle_pct  = (phase == 3) ? 0 : IDLE_PCT;
      out_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        len     = pick_len();
        t_first = rand_time();
        t_last  = t_first + pick_span(cur_ts);
        if ($urandom_range(0, 7) == 0) send_req(len, t_first, t_last);
        else send_req(len, t_last, t_first);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
